// ===== src/tlb_page_table_translator_defines.svh =====
// Assertion helpers shared by the translator modules.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

// Clocked check, switched off while reset is active.
`define TLBPT_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Clocked check that must also hold during reset.
`define TLBPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/tlbpt_pkg.sv =====
package tlbpt_pkg;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned PAGE_W  = 8;
  localparam int unsigned FRAME_W = 8;
  localparam int unsigned NEXT_W  = 9;
  localparam int unsigned COUNT_W = 16;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [PAGE_W-1:0]  page_t;
  typedef logic [FRAME_W-1:0] frame_t;
  typedef logic [NEXT_W-1:0]  next_t;
  typedef logic [COUNT_W-1:0] count_t;

  // TLB lookup status
  typedef struct packed {
    logic   hit;
    frame_t frame;
  } tlb_look_t;

  // TLB update request: commit the current lookup, insert on a fault
  typedef struct packed {
    logic   commit;
    logic   insert;
    page_t  page;
    frame_t frame;
  } tlb_cmd_t;

  // Saturating increment for the statistics counters
  function automatic count_t sat_inc(count_t v);
    count_t r;
    r = (v == '1) ? v : v + count_t'(1);
    return r;
  endfunction

endpackage

// ===== src/tlbpt_if.sv =====
// Request channel: logical address in
interface tlbpt_req_if;
  logic              valid;
  logic              ready;
  tlbpt_pkg::addr_t  logical_address;

  modport source (output valid, output logical_address, input ready);
  modport sink   (input valid, input logical_address, output ready);
endinterface

// Response channel: translation result out
interface tlbpt_rsp_if;
  logic              valid;
  logic              ready;
  tlbpt_pkg::addr_t  physical_address;
  logic              tlb_hit;
  logic              page_fault;
  tlbpt_pkg::count_t fault_total;
  tlbpt_pkg::count_t hit_total;

  modport source (output valid, output physical_address, output tlb_hit,
                  output page_fault, output fault_total, output hit_total,
                  input ready);
  modport sink   (input valid, input physical_address, input tlb_hit,
                  input page_fault, input fault_total, input hit_total,
                  output ready);
endinterface

// ===== src/tlb_page_table_translator.sv =====
// Flow: the page table is read into its output registers, then the result is decided
// and registered once the output register is free; no new request is taken until
// the current one has been decided.
// Reset: asynchronous; TLB emptied, counters and next frame cleared, then a
// sweep clears the present memory before requests are taken.
`include "tlb_page_table_translator_defines.svh"

module tlb_page_table_translator #(
  parameter int unsigned TLB_ENTRIES = 16,
  parameter int unsigned PAGE_COUNT  = 256,
  parameter int unsigned PAGE_BYTES  = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tlbpt_req_if.sink          req_i,
  tlbpt_rsp_if.source        rsp_o
);

  localparam int unsigned OFFS_W = $clog2(PAGE_BYTES);
  localparam int unsigned PG_W   = $clog2(PAGE_COUNT);

  logic                 busy_q;
  logic                 out_valid_q;
  logic [PG_W-1:0]      page_q;
  logic [OFFS_W-1:0]    offset_q;
  tlbpt_pkg::addr_t     phys_q;
  logic                 hit_q;
  logic                 fault_q;
  tlbpt_pkg::next_t     next_frame_q;
  tlbpt_pkg::count_t    fault_cnt_q;
  tlbpt_pkg::count_t    hit_cnt_q;

  tlbpt_pkg::addr_t     page_full;
  logic [PG_W-1:0]      in_page;
  logic [PG_W-1:0]      rd_page;
  logic                 in_fire;
  logic                 done;
  logic                 pt_ready;
  logic                 pt_present;
  tlbpt_pkg::frame_t    pt_frame;
  tlbpt_pkg::tlb_look_t look;
  tlbpt_pkg::tlb_cmd_t  cmd;
  logic                 fault;
  tlbpt_pkg::frame_t    frame_sel;

  // Address split
  assign page_full = req_i.logical_address >> OFFS_W;
  assign in_page   = page_full[PG_W-1:0];

  assign req_i.ready = !busy_q && pt_ready;
  assign in_fire     = req_i.valid && req_i.ready;

  // Read address held while the request waits for the output register
  assign rd_page = in_fire ? in_page : page_q;

  // Decide step completes once the output register is free
  assign done = busy_q && (!out_valid_q || rsp_o.ready);

  tlbpt_ptab #(
    .PAGE_COUNT (PAGE_COUNT)
  ) u_ptab (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_page_i  (rd_page),
    .wr_en_i    (done && fault),
    .wr_page_i  (page_q),
    .wr_frame_i (frame_sel),
    .present_o  (pt_present),
    .frame_o    (pt_frame),
    .ready_o    (pt_ready)
  );

  // Resolve: TLB hit, page table hit, or fault with a fresh frame
  assign fault     = !look.hit && !pt_present;
  assign frame_sel = look.hit   ? look.frame :
                     pt_present ? pt_frame   : next_frame_q[tlbpt_pkg::FRAME_W-1:0];

  assign cmd.commit = done;
  assign cmd.insert = fault;
  assign cmd.page   = tlbpt_pkg::page_t'(page_q);
  assign cmd.frame  = frame_sel;

  tlbpt_tlb #(
    .TLB_ENTRIES (TLB_ENTRIES)
  ) u_tlb (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .page_i (tlbpt_pkg::page_t'(page_q)),
    .cmd_i  (cmd),
    .look_o (look)
  );

  // Request payload and result register
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      page_q   <= in_page;
      offset_q <= req_i.logical_address[OFFS_W-1:0];
    end
    if (done) begin
      phys_q  <= tlbpt_pkg::ADDR_W'({frame_sel, offset_q});
      hit_q   <= look.hit;
      fault_q <= fault;
    end
  end

  // Control, frame allocator and statistics
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      next_frame_q <= '0;
      fault_cnt_q  <= '0;
      hit_cnt_q    <= '0;
    end else begin
      if (in_fire) begin
        busy_q <= 1'b1;
      end else if (done) begin
        busy_q <= 1'b0;
      end
      if (done) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (done && look.hit) begin
        hit_cnt_q <= tlbpt_pkg::sat_inc(hit_cnt_q);
      end
      if (done && fault) begin
        fault_cnt_q <= tlbpt_pkg::sat_inc(fault_cnt_q);
        if (next_frame_q != '1) begin
          next_frame_q <= next_frame_q + tlbpt_pkg::next_t'(1);
        end
      end
    end
  end

  assign rsp_o.valid            = out_valid_q;
  assign rsp_o.physical_address = phys_q;
  assign rsp_o.tlb_hit          = hit_q;
  assign rsp_o.page_fault       = fault_q;
  assign rsp_o.fault_total      = fault_cnt_q;
  assign rsp_o.hit_total        = hit_cnt_q;

  `TLBPT_ASSERT(a_hit_fault_excl, clk_i, rst_ni, out_valid_q |-> !(hit_q && fault_q), "response flags both hit and fault")
  `TLBPT_ASSERT(a_fault_counted, clk_i, rst_ni, (out_valid_q && fault_q) |-> (fault_cnt_q != '0), "fault response with zero fault count")
  `TLBPT_ASSERT(a_hit_counted, clk_i, rst_ni, (out_valid_q && hit_q) |-> (hit_cnt_q != '0), "hit response with zero hit count")

endmodule

// ===== src/tlbpt_tlb.sv =====
`include "tlb_page_table_translator_defines.svh"

// LRU-ordered TLB: entry 0 is oldest, the last entry is most recent.
module tlbpt_tlb #(
  parameter int unsigned TLB_ENTRIES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tlbpt_pkg::page_t    page_i,
  input  tlbpt_pkg::tlb_cmd_t cmd_i,
  output tlbpt_pkg::tlb_look_t look_o
);

  localparam int unsigned IDX_W = $clog2(TLB_ENTRIES);

  tlbpt_pkg::page_t  page_q  [TLB_ENTRIES];
  tlbpt_pkg::frame_t frame_q [TLB_ENTRIES];
  logic [TLB_ENTRIES-1:0] valid_q;

  logic              hit;
  logic [IDX_W-1:0]  hit_idx;
  logic              do_upd;
  logic [IDX_W-1:0]  pos;
  tlbpt_pkg::page_t  tail_page;
  tlbpt_pkg::frame_t tail_frame;

  // Associative compare; the match nearest the oldest end wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int j = TLB_ENTRIES - 1; j >= 0; j--) begin
      if (valid_q[j] && (page_q[j] == page_i)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(j);
      end
    end
  end

  assign look_o.hit   = hit;
  assign look_o.frame = frame_q[hit_idx];

  // Hit moves its entry to the tail; insert drops the oldest entry
  assign do_upd     = cmd_i.commit && (cmd_i.insert || hit);
  assign pos        = cmd_i.insert ? '0 : hit_idx;
  assign tail_page  = cmd_i.insert ? cmd_i.page  : page_q[hit_idx];
  assign tail_frame = cmd_i.insert ? cmd_i.frame : frame_q[hit_idx];

  // Entry payload, shifted toward oldest from the update position
  always_ff @(posedge clk_i) begin
    if (do_upd) begin
      for (int j = 0; j < TLB_ENTRIES - 1; j++) begin
        if (IDX_W'(j) >= pos) begin
          page_q[j]  <= page_q[j+1];
          frame_q[j] <= frame_q[j+1];
        end
      end
      page_q[TLB_ENTRIES-1]  <= tail_page;
      frame_q[TLB_ENTRIES-1] <= tail_frame;
    end
  end

  // Valid bits follow the same shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (do_upd) begin
      for (int j = 0; j < TLB_ENTRIES - 1; j++) begin
        if (IDX_W'(j) >= pos) begin
          valid_q[j] <= valid_q[j+1];
        end
      end
      valid_q[TLB_ENTRIES-1] <= 1'b1;
    end
  end

  `TLBPT_ASSERT(a_insert_at_tail, clk_i, rst_ni, (cmd_i.commit && cmd_i.insert) |=> (valid_q[TLB_ENTRIES-1] && page_q[TLB_ENTRIES-1] == $past(cmd_i.page)), "inserted mapping missing at TLB tail")

endmodule

// ===== src/tlbpt_ptab.sv =====
`include "tlb_page_table_translator_defines.svh"

// Page table: present bits and frame numbers in two synchronous memories.
// The present memory is swept to zero after reset.
module tlbpt_ptab #(
  parameter int unsigned PAGE_COUNT = 256
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [$clog2(PAGE_COUNT)-1:0] rd_page_i,
  input  logic                       wr_en_i,
  input  logic [$clog2(PAGE_COUNT)-1:0] wr_page_i,
  input  tlbpt_pkg::frame_t          wr_frame_i,
  output logic                       present_o,
  output tlbpt_pkg::frame_t          frame_o,
  output logic                       ready_o
);

  localparam int unsigned PG_W = $clog2(PAGE_COUNT);

  logic              present_mem [PAGE_COUNT];
  tlbpt_pkg::frame_t frame_mem   [PAGE_COUNT];

  logic              clr_busy_q;
  logic [PG_W-1:0]   clr_cnt_q;
  logic              present_q;
  tlbpt_pkg::frame_t frame_q;

  // Clearing sweep, one entry a cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      clr_cnt_q <= clr_cnt_q + PG_W'(1);
      if (clr_cnt_q == PG_W'(PAGE_COUNT - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  // Present memory
  always_ff @(posedge clk_i) begin
    if (clr_busy_q) begin
      present_mem[clr_cnt_q] <= 1'b0;
    end else if (wr_en_i) begin
      present_mem[wr_page_i] <= 1'b1;
    end
    present_q <= present_mem[rd_page_i];
  end

  // Frame memory
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      frame_mem[wr_page_i] <= wr_frame_i;
    end
    frame_q <= frame_mem[rd_page_i];
  end

  assign present_o = present_q;
  assign frame_o   = frame_q;
  assign ready_o   = !clr_busy_q;

  `TLBPT_ASSERT_ALWAYS(a_no_write_in_clear, clk_i, wr_en_i |-> !clr_busy_q, "page table written during clearing sweep")

endmodule
